>>> hw/rtl/pfd_pkg.sv
// Shared types and constants for the periodic flow detector.
`timescale 1ns / 1ps

package pfd_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_LOWER    = 2'd0;
  localparam logic [1:0] REG_UPPER    = 2'd1;
  localparam logic [1:0] REG_MIN_DUR  = 2'd2;
  localparam logic [1:0] REG_MAX_BAT  = 2'd3;

  // Field widths
  localparam int INTERVAL_W = 31;
  localparam int BATCH_W    = 16;
  // lower_interval / 5 fits in 29 bits
  localparam int LIMIT_W    = 29;

  // x / 5 == (x * 0xCCCCCCCD) >> 34 for any x below 2^32
  localparam logic [31:0] FIFTH_RECIP = 32'hCCCC_CCCD;
  localparam int          FIFTH_SHIFT = 34;

  localparam logic [INTERVAL_W-1:0] LOWER_RST   = 31'd1000000;
  localparam logic [INTERVAL_W-1:0] UPPER_RST   = 31'd2000000;
  localparam logic [INTERVAL_W-1:0] MIN_DUR_RST = 31'd30000000;
  localparam logic [BATCH_W-1:0]    MAX_BAT_RST = 16'd4;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST   = 29'd200000;

  localparam logic [BATCH_W-1:0] BURST_MAX = 16'hFFFF;

  // Lookup outcome carried from front to back
  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_NEW  = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic [63:0] flow_id;
    logic [63:0] timestamp;
  } pfd_in_t;

  typedef struct packed {
    logic        report_valid;
    logic [63:0] report_flow;
    logic [63:0] run_start_time;
    logic        table_full;
  } pfd_out_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] lower_interval;
    logic [INTERVAL_W-1:0] upper_interval;
    logic [INTERVAL_W-1:0] min_duration;
    logic [BATCH_W-1:0]    max_batch;
    logic [LIMIT_W-1:0]    burst_limit;
  } pfd_cfg_t;

  typedef struct packed {
    logic [63:0] flow_id;
    logic [63:0] timestamp;
    logic [1:0]  kind;
  } pfd_job_t;

  typedef struct packed {
    logic [63:0]        last_arrival;
    logic [63:0]        run_start;
    logic [BATCH_W-1:0] burst_count;
    logic               already_reported;
  } pfd_entry_t;

endpackage

>>> hw/rtl/periodic_flow_detector.sv
// Top level of the periodic flow detector.
`timescale 1ns / 1ps

// Periodic flow detector: one packet beat (flow id, timestamp) in, one result
// beat out. The front end looks the flow up by scanning the stored keys one a
// cycle, so a lookup takes longer the more flows are stored; the key table's
// single read port sets that pace. The back end then reads, updates and writes
// the flow's state and loads the result register. A two-entry queue lets the
// next lookup run while the previous update waits on the output. Flows fill
// slots in order, so the fill count marks which slots hold data and no clearing
// pass is needed after reset. Register writes must be made only while idle.
module periodic_flow_detector #(
  parameter int FLOW_SLOTS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfd_pkg::ADDR_W-1:0] paddr,
  input  logic [pfd_pkg::DATA_W-1:0] pwdata,
  output logic [pfd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pfd_pkg::pfd_in_t           in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pfd_pkg::pfd_out_t          out_item
);
  import pfd_pkg::*;

  localparam int IDX_W = $clog2(FLOW_SLOTS);
  localparam int Q_W   = $bits(pfd_job_t) + IDX_W;

  pfd_cfg_t         cfg;
  logic             fj_valid;
  logic             fj_ready;
  pfd_job_t         fj;
  logic [IDX_W-1:0] fj_slot;
  logic             bj_valid;
  logic             bj_ready;
  pfd_job_t         bj;
  logic [IDX_W-1:0] bj_slot;
  logic [Q_W-1:0]   q_wdata;
  logic [Q_W-1:0]   q_rdata;

  pfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfd_front #(.FLOW_SLOTS(FLOW_SLOTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj),
    .job_slot  (fj_slot)
  );

  assign q_wdata     = {fj, fj_slot};
  assign {bj, bj_slot} = q_rdata;

  pfd_queue #(.WIDTH(Q_W)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (q_wdata),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (q_rdata)
  );

  pfd_back #(.FLOW_SLOTS(FLOW_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_in    (bj),
    .slot_in   (bj_slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/pfd_cfg.sv
// APB configuration registers, with the burst limit precomputed on write.
`timescale 1ns / 1ps

module pfd_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pfd_pkg::ADDR_W-1:0] paddr,
  input  logic [pfd_pkg::DATA_W-1:0] pwdata,
  output logic [pfd_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output pfd_pkg::pfd_cfg_t         cfg
);
  import pfd_pkg::*;

  logic        wr_en;
  logic [1:0]  reg_sel;
  logic [62:0] fifth_prod;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  // Reciprocal multiply gives lower_interval / 5 exactly
  assign fifth_prod = 63'(pwdata[INTERVAL_W-1:0]) * 63'(FIFTH_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_interval <= LOWER_RST;
      cfg.upper_interval <= UPPER_RST;
      cfg.min_duration   <= MIN_DUR_RST;
      cfg.max_batch      <= MAX_BAT_RST;
      cfg.burst_limit    <= LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LOWER: begin
          cfg.lower_interval <= pwdata[INTERVAL_W-1:0];
          cfg.burst_limit    <= fifth_prod[FIFTH_SHIFT+LIMIT_W-1:FIFTH_SHIFT];
        end
        REG_UPPER:   cfg.upper_interval <= pwdata[INTERVAL_W-1:0];
        REG_MIN_DUR: cfg.min_duration   <= pwdata[INTERVAL_W-1:0];
        REG_MAX_BAT: cfg.max_batch      <= pwdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_LOWER:   prdata = DATA_W'(cfg.lower_interval);
      REG_UPPER:   prdata = DATA_W'(cfg.upper_interval);
      REG_MIN_DUR: prdata = DATA_W'(cfg.min_duration);
      REG_MAX_BAT: prdata = DATA_W'(cfg.max_batch);
      default:     prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pfd_front.sv
// Front end: accepts packets, scans the key table and allocates new flows.
`timescale 1ns / 1ps

module pfd_front #(
  parameter int FLOW_SLOTS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pfd_pkg::pfd_in_t                       in_item,
  output logic                                   job_valid,
  input  logic                                   job_ready,
  output pfd_pkg::pfd_job_t                      job,
  output logic [$clog2(FLOW_SLOTS)-1:0]          job_slot
);
  import pfd_pkg::*;

  localparam int IDX_W = $clog2(FLOW_SLOTS);
  localparam int CNT_W = $clog2(FLOW_SLOTS + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SCAN = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] issue_idx;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [63:0]      key_q;
  logic             key_re;
  logic             key_we;
  logic             hit;
  logic             more;

  logic [63:0] key_mem [FLOW_SLOTS];

  assign in_ready  = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign hit       = rd_pend && (key_q == job.flow_id);
  assign more      = (issue_idx < fill);
  assign key_re    = (state == F_SCAN) && !hit && more;
  assign key_we    = job_valid && job_ready && (job.kind == KIND_NEW);

  // Key table: one read per cycle during the scan, one write on allocation
  always_ff @(posedge clk) begin
    if (key_re) key_q <= key_mem[issue_idx[IDX_W-1:0]];
    if (key_we) key_mem[job_slot] <= job.flow_id;
  end

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      fill      <= '0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            issue_idx <= '0;
            rd_pend   <= 1'b0;
            state     <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (hit) begin
            state <= F_PUSH;
          end else if (more) begin
            rd_pend   <= 1'b1;
            issue_idx <= issue_idx + 1'b1;
          end else begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
            if (job.kind == KIND_NEW) fill <= fill + 1'b1;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job.flow_id   <= in_item.flow_id;
      job.timestamp <= in_item.timestamp;
    end
    if (key_re) rd_idx <= issue_idx[IDX_W-1:0];
    if (state == F_SCAN) begin
      if (hit) begin
        job.kind <= KIND_HIT;
        job_slot <= rd_idx;
      end else if (!more) begin
        job.kind <= (fill == CNT_W'(FLOW_SLOTS)) ? KIND_FULL : KIND_NEW;
        job_slot <= fill[IDX_W-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/pfd_queue.sv
// Two-entry queue between lookup and update.
`timescale 1ns / 1ps

module pfd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import pfd_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/pfd_back.sv
// Back end: per-flow state update and the result register.
`timescale 1ns / 1ps

module pfd_back #(
  parameter int FLOW_SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfd_pkg::pfd_cfg_t             cfg,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  pfd_pkg::pfd_job_t             job_in,
  input  logic [$clog2(FLOW_SLOTS)-1:0] slot_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfd_pkg::pfd_out_t             out_item
);
  import pfd_pkg::*;

  localparam int IDX_W = $clog2(FLOW_SLOTS);

  localparam logic [1:0] B_IDLE   = 2'd0;
  localparam logic [1:0] B_DIFF   = 2'd1;
  localparam logic [1:0] B_DECIDE = 2'd2;

  logic [1:0]       state;
  pfd_job_t         job;
  logic [IDX_W-1:0] slot;
  pfd_entry_t       ent_q;
  pfd_entry_t       ent_next;
  logic             ent_we;
  pfd_out_t         res;
  logic             pop;
  logic             fire;

  logic [63:0]        gap;
  logic [63:0]        run_len;
  logic               is_burst;
  logic               gap_low;
  logic               gap_high;
  logic               run_long;
  logic [BATCH_W-1:0] burst_inc;

  pfd_entry_t state_mem [FLOW_SLOTS];

  assign job_ready = (state == B_IDLE);
  assign pop       = job_valid && job_ready;
  assign fire      = (state == B_DECIDE) && (!out_valid || out_ready);

  // Flow state memory: read when a job is taken, written when a hit or new-flow job retires
  always_ff @(posedge clk) begin
    if (pop) ent_q <= state_mem[slot_in];
    if (fire && ent_we) state_mem[slot] <= ent_next;
  end

  // Gap and run length against the thresholds
  assign gap     = job.timestamp - ent_q.last_arrival;
  assign run_len = job.timestamp - ent_q.run_start;

  always_ff @(posedge clk) begin
    if (state == B_DIFF) begin
      is_burst <= (gap[63:LIMIT_W] == '0) && (gap[LIMIT_W-1:0] < cfg.burst_limit);
      gap_low  <= (gap[63:INTERVAL_W] == '0) &&
                  (gap[INTERVAL_W-1:0] < cfg.lower_interval);
      gap_high <= (gap[63:INTERVAL_W] != '0) ||
                  (gap[INTERVAL_W-1:0] > cfg.upper_interval);
      run_long <= (run_len[63:INTERVAL_W] != '0) ||
                  (run_len[INTERVAL_W-1:0] >= cfg.min_duration);
    end
  end

  assign burst_inc = (ent_q.burst_count != BURST_MAX) ?
                     ent_q.burst_count + 1'b1 : ent_q.burst_count;

  // Next entry and result
  always_comb begin
    ent_next           = ent_q;
    ent_we             = 1'b0;
    res.report_valid   = 1'b0;
    res.report_flow    = job.flow_id;
    res.run_start_time = '0;
    res.table_full     = 1'b0;
    case (job.kind)
      KIND_NEW: begin
        ent_we                    = 1'b1;
        ent_next.last_arrival     = job.timestamp;
        ent_next.run_start        = job.timestamp;
        ent_next.burst_count      = BATCH_W'(1);
        ent_next.already_reported = 1'b0;
      end
      KIND_FULL: begin
        res.table_full = 1'b1;
      end
      KIND_HIT: begin
        ent_we = 1'b1;
        if (is_burst) begin
          ent_next.burst_count = burst_inc;
          if (burst_inc > cfg.max_batch) ent_next.run_start = '0;
        end else begin
          ent_next.last_arrival = job.timestamp;
          ent_next.burst_count  = BATCH_W'(1);
          if (ent_q.run_start == '0) begin
            ent_next.run_start = job.timestamp;
          end else if (gap_low || gap_high) begin
            ent_next.run_start = '0;
          end else if (run_long && !ent_q.already_reported) begin
            ent_next.already_reported = 1'b1;
            res.report_valid          = 1'b1;
            res.run_start_time        = ent_q.run_start;
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE:   if (pop) state <= (job_in.kind == KIND_HIT) ? B_DIFF : B_DECIDE;
        B_DIFF:   state <= B_DECIDE;
        B_DECIDE: if (fire) state <= B_IDLE;
        default:  state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job  <= job_in;
      slot <= slot_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_item <= res;
  end

endmodule

>>> hw/rtl/pfd_checker.sv
// Port-level checks for the periodic flow detector, bound to the top level.
`timescale 1ns / 1ps

module pfd_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pfd_pkg::pfd_out_t out_item
);
  import pfd_pkg::*;

  // No result may appear straight out of reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result beat right after reset");

  // A report never comes with a dropped flow
  a_report_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.report_valid |-> !out_item.table_full)
    else $error("report and table_full together");

  // Run start is zero unless reported
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.report_valid |-> out_item.run_start_time == 64'd0)
    else $error("run start shown without report");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  // Input ready is low in the cycle after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a beat");

endmodule

bind periodic_flow_detector pfd_checker u_pfd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the periodic flow detector.
`timescale 1ns / 1ps

module tb;
  import pfd_pkg::*;

  localparam int          FLOW_SLOTS     = 256;
  localparam int          HOT_SLOTS      = 6;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          MAX_PRINTED    = 100;
  localparam int          PHASE_BEATS    = 290;
  localparam logic [31:0] BURST_DIV      = 32'd5;
  localparam logic [31:0] INTERVAL_MAX   = 32'h7FFF_FFFF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pfd_in_t             in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pfd_out_t            out_item;

  // Predictor copy of the configuration registers
  logic [INTERVAL_W-1:0] cfg_lower = LOWER_RST;
  logic [INTERVAL_W-1:0] cfg_upper = UPPER_RST;
  logic [INTERVAL_W-1:0] cfg_min_dur = MIN_DUR_RST;
  logic [BATCH_W-1:0]    cfg_max_batch = MAX_BAT_RST;

  // Predictor copy of the flow table; slots fill in order
  logic [63:0]        slot_key      [FLOW_SLOTS];
  logic [63:0]        slot_last     [FLOW_SLOTS];
  logic [63:0]        slot_run      [FLOW_SLOTS];
  logic [BATCH_W-1:0] slot_burst    [FLOW_SLOTS];
  logic               slot_reported [FLOW_SLOTS];
  int                 slots_filled = 0;

  pfd_out_t pending_results[$];
  int       mismatches = 0;
  int       tx_idle_max = 6;
  int       rx_idle_max = 6;
  int       rx_hold_req = 0;
  int       quiet_cycles = 0;
  int       hot_slot [HOT_SLOTS];

  periodic_flow_detector #(.FLOW_SLOTS(FLOW_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: ends the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // Per-packet detector prediction; updates the table copy
  function automatic pfd_out_t predict_detection(input pfd_in_t pkt);
    pfd_out_t    res;
    int          s;
    logic [63:0] gap;
    logic [63:0] burst_lim;
    res = '0;
    res.report_flow = pkt.flow_id;
    s = -1;
    for (int i = 0; i < slots_filled; i++) begin
      if (s < 0 && slot_key[i] == pkt.flow_id) s = i;
    end
    // unknown flow: take the next slot or flag a full table
    if (s < 0) begin
      if (slots_filled < FLOW_SLOTS) begin
        slot_key[slots_filled]      = pkt.flow_id;
        slot_last[slots_filled]     = pkt.timestamp;
        slot_run[slots_filled]      = pkt.timestamp;
        slot_burst[slots_filled]    = 16'd1;
        slot_reported[slots_filled] = 1'b0;
        slots_filled++;
      end else begin
        res.table_full = 1'b1;
      end
      return res;
    end
    gap = pkt.timestamp - slot_last[s];
    burst_lim = {33'd0, cfg_lower} / 64'(BURST_DIV);
    // close packet: grow the burst, too long a burst kills the run
    if (gap < burst_lim) begin
      if (slot_burst[s] != BURST_MAX) slot_burst[s] = slot_burst[s] + 16'd1;
      if (slot_burst[s] > cfg_max_batch) slot_run[s] = '0;
      return res;
    end
    slot_last[s] = pkt.timestamp;
    slot_burst[s] = 16'd1;
    if (slot_run[s] == '0) begin
      slot_run[s] = pkt.timestamp;
      return res;
    end
    if (gap < {33'd0, cfg_lower} || gap > {33'd0, cfg_upper}) begin
      slot_run[s] = '0;
      return res;
    end
    if (pkt.timestamp - slot_run[s] >= {33'd0, cfg_min_dur} && !slot_reported[s]) begin
      slot_reported[s] = 1'b1;
      res.report_valid = 1'b1;
      res.run_start_time = slot_run[s];
    end
    return res;
  endfunction

  // APB write; unused upper data bits carry noise
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] data;
    data = val;
    if (idx == REG_MAX_BAT) data[31:16] = 16'($urandom);
    else data[31] = 1'($urandom_range(0, 1));
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOWER:   cfg_lower = data[30:0];
      REG_UPPER:   cfg_upper = data[30:0];
      REG_MIN_DUR: cfg_min_dur = data[30:0];
      REG_MAX_BAT: cfg_max_batch = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [31:0] lower, input logic [31:0] upper,
                              input logic [31:0] min_dur, input logic [31:0] max_batch);
    write_reg(REG_LOWER, lower);
    write_reg(REG_UPPER, upper);
    write_reg(REG_MIN_DUR, min_dur);
    write_reg(REG_MAX_BAT, max_batch);
  endtask

  // Send one packet beat; returns at the falling edge after acceptance
  task automatic send_packet(input logic [63:0] id, input logic [63:0] stamp);
    int      idle;
    pfd_in_t pkt;
    idle = $urandom_range(0, tx_idle_max);
    pkt.flow_id = id;
    pkt.timestamp = stamp;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_item <= pkt;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_detection(pkt));
    @(negedge clk);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [63:0] start_stamp();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
      2:       return 64'($urandom_range(0, 3));
      default: return 64'($urandom);
    endcase
  endfunction

  // Gap shaped around the current interval window
  function automatic logic [63:0] random_gap();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] lim;
    int          r;
    lo = {1'b0, cfg_lower};
    hi = {1'b0, cfg_upper};
    lim = lo / BURST_DIV;
    r = $urandom_range(0, 99);
    if (r < 55) return (hi >= lo) ? 64'(lo) + 64'($urandom_range(0, hi - lo)) : 64'(lo);
    if (r < 75) return (lim == 0) ? 64'd0 : 64'($urandom_range(0, lim - 1));
    if (r < 83) return 64'(lo) - 64'($urandom_range(1, 3));
    if (r < 91) return 64'(hi) + 64'($urandom_range(1, 3));
    if (r < 96) return ($urandom_range(0, 1) != 0) ? 64'(lo) : 64'(hi);
    return {$urandom, $urandom};
  endfunction

  // Pick a few stored flows, unreported where possible, to carry runs
  task automatic refresh_hot_set();
    int s;
    for (int h = 0; h < HOT_SLOTS; h++) begin
      hot_slot[h] = -1;
      for (int t = 0; t < 20 && slots_filled > 0; t++) begin
        s = $urandom_range(0, slots_filled - 1);
        if (!slot_reported[s]) begin
          hot_slot[h] = s;
          break;
        end
      end
    end
  endtask

  task automatic send_random_packet();
    int pick;
    int s;
    int filled_prior;
    pick = $urandom_range(0, 99);
    filled_prior = slots_filled;
    if (slots_filled == 0 || pick < 12) begin
      send_packet({$urandom, $urandom}, start_stamp());
      if (slots_filled > filled_prior)
        hot_slot[$urandom_range(0, HOT_SLOTS - 1)] = slots_filled - 1;
    end else begin
      s = (pick < 80) ? hot_slot[$urandom_range(0, HOT_SLOTS - 1)] : -1;
      if (s < 0) s = $urandom_range(0, slots_filled - 1);
      send_packet(slot_key[s], slot_last[s] + random_gap());
    end
  endtask

  // Default registers: burst edge, short gap, reopen, upper bound
  task automatic test_reset_config();
    logic [63:0] stamp;
    stamp = 64'd1000;
    send_packet(64'd0, stamp);
    send_packet(64'd0, stamp + 64'd199_999);
    stamp = stamp + 64'd200_000;
    send_packet(64'd0, stamp);
    stamp = stamp + 64'd1_500_000;
    send_packet(64'd0, stamp);
    stamp = stamp + 64'd2_000_000;
    send_packet(64'd0, stamp);
    stamp = stamp + 64'd2_000_001;
    send_packet(64'd0, stamp);
    drain();
  endtask

  // Run at time zero reads as no run; report once; burst breaks a run
  task automatic test_run_reporting();
    logic [63:0] flow_a;
    logic [63:0] flow_b;
    flow_a = '1;
    flow_b = 64'h5555_5555_5555_5555;
    write_config(32'd100, 32'd200, 32'd300, 32'd2);
    send_packet(flow_a, 64'd0);
    send_packet(flow_a, 64'd150);
    send_packet(flow_a, 64'd300);
    send_packet(flow_a, 64'd450);
    send_packet(flow_a, 64'd600);
    send_packet(flow_b, 64'd1000);
    send_packet(flow_b, 64'd1019);
    send_packet(flow_b, 64'd1010);
    send_packet(flow_b, 64'd1100);
    send_packet(flow_b, 64'd1300);
    send_packet(flow_b, 64'd1400);
    drain();
  endtask

  // Gaps and run length across the 64-bit wrap; time running backward
  task automatic test_time_wrap();
    logic [63:0] flow_c;
    flow_c = 64'hAAAA_AAAA_AAAA_AAAA;
    send_packet(flow_c, 64'd0 - 64'd250);
    send_packet(flow_c, 64'd0 - 64'd100);
    send_packet(flow_c, 64'd50);
    send_packet(flow_c, 64'd60);
    send_packet(flow_c, 64'd0);
    drain();
  endtask

  // Registers at their extremes
  task automatic test_config_extremes();
    logic [63:0] flow_d;
    logic [63:0] flow_e;
    logic [63:0] stamp;
    flow_d = 64'h0123_4567_89AB_CDEF;
    flow_e = 64'h8000_0000_0000_0001;
    write_config(32'd0, INTERVAL_MAX, 32'd0, 32'd0);
    stamp = '1;
    send_packet(flow_d, stamp);
    send_packet(flow_d, stamp);
    stamp = stamp + 64'(INTERVAL_MAX);
    send_packet(flow_d, stamp);
    stamp = stamp + 64'(INTERVAL_MAX) + 64'd1;
    send_packet(flow_d, stamp);
    drain();
    write_config(INTERVAL_MAX, INTERVAL_MAX, INTERVAL_MAX, 32'hFFFF);
    stamp = 64'd7;
    send_packet(flow_e, stamp);
    stamp = stamp + 64'(INTERVAL_MAX);
    send_packet(flow_e, stamp);
    send_packet(flow_e, stamp + 64'd1);
    send_packet(flow_e, stamp + 64'(INTERVAL_MAX) - 64'd1);
    drain();
  endtask

  // One random phase under a fresh register setting
  task automatic test_random_traffic(input int beats, input bit wide);
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] min_dur;
    logic [31:0] max_batch;
    lower = wide ? $urandom_range(32'd1 << 20, INTERVAL_MAX) : $urandom_range(20, 2000);
    if ($urandom_range(0, 9) == 0) upper = $urandom_range(0, lower);
    else upper = lower + $urandom_range(0, wide ? INTERVAL_MAX - lower : lower);
    min_dur = wide ? $urandom_range(0, INTERVAL_MAX) : upper * $urandom_range(0, 6);
    max_batch = ($urandom_range(0, 7) == 0) ? 32'hFFFF : $urandom_range(0, 5);
    write_config(lower, upper, min_dur, max_batch);
    refresh_hot_set();
    repeat (beats) send_random_packet();
    drain();
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_output_backpressure();
    int saved_idle;
    saved_idle = tx_idle_max;
    tx_idle_max = 0;
    rx_hold_req = 1500;
    repeat (12) send_random_packet();
    drain();
    tx_idle_max = saved_idle;
  endtask

  // Fill every slot, then offer more new flows and a known one
  task automatic test_table_full();
    while (slots_filled < FLOW_SLOTS) send_packet({$urandom, $urandom}, start_stamp());
    repeat (6) send_packet({$urandom, $urandom}, start_stamp());
    send_packet(slot_key[0], slot_last[0] + 64'({1'b0, cfg_lower}));
    drain();
  endtask

  // Both sides without idle cycles
  task automatic test_no_idle();
    tx_idle_max = 0;
    rx_idle_max = 0;
    test_random_traffic(PHASE_BEATS, 1'b0);
    tx_idle_max = 6;
    rx_idle_max = 6;
  endtask

  // Result side: random stalls, field-by-field check against the oldest prediction
  initial begin : result_checker
    int       hold;
    pfd_out_t want;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        hold = $urandom_range(0, rx_idle_max);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with none pending, flow %h",
                                out_item.report_flow));
      end else begin
        want = pending_results.pop_front();
        if (out_item.report_valid !== want.report_valid)
          flag_mismatch($sformatf("flow %h report_valid %b want %b", want.report_flow,
                                  out_item.report_valid, want.report_valid));
        if (out_item.report_flow !== want.report_flow)
          flag_mismatch($sformatf("report_flow %h want %h", out_item.report_flow,
                                  want.report_flow));
        if (out_item.run_start_time !== want.run_start_time)
          flag_mismatch($sformatf("flow %h run_start_time %h want %h", want.report_flow,
                                  out_item.run_start_time, want.run_start_time));
        if (out_item.table_full !== want.table_full)
          flag_mismatch($sformatf("flow %h table_full %b want %b", want.report_flow,
                                  out_item.table_full, want.table_full));
      end
      @(negedge clk);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_run_reporting();
    test_time_wrap();
    test_config_extremes();
    test_random_traffic(PHASE_BEATS, 1'b0);
    test_output_backpressure();
    test_random_traffic(PHASE_BEATS, 1'b0);
    test_table_full();
    test_random_traffic(PHASE_BEATS, 1'b1);
    test_no_idle();
    test_random_traffic(PHASE_BEATS, 1'b0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
